// File: src/periodic_task_scheduler_unit_macros.svh
// Assertion macros for the periodic task scheduler unit
`ifndef PERIODIC_TASK_SCHEDULER_UNIT_MACROS_SVH
`define PERIODIC_TASK_SCHEDULER_UNIT_MACROS_SVH
`ifndef ASSERT_OFF
`define PTS_ASSERT(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error("%m failed");
`define PTS_ASSERT_NR(label, clk, prop) \
	label: assert property (@(posedge clk) prop) else $error("%m failed");
`else
`define PTS_ASSERT(label, clk, rst_n, prop)
`define PTS_ASSERT_NR(label, clk, prop)
`endif
`endif

// File: src/pts_pkg.sv
// Shared types and codes of the periodic task scheduler
package pts_pkg;
	localparam logic [3:0] KIND_TICK = 4'd0;
	localparam logic [3:0] KIND_CREATE = 4'd1;
	localparam logic [3:0] KIND_DELETE = 4'd2;
	localparam logic [3:0] KIND_SUSPEND = 4'd3;
	localparam logic [3:0] KIND_RESUME = 4'd4;
	localparam logic [3:0] KIND_WAIT = 4'd5;
	localparam logic [3:0] KIND_FINISH = 4'd6;
	localparam logic [3:0] KIND_TLOAD = 4'd7;
	localparam logic [3:0] KIND_TOTAL = 4'd8;

	localparam logic [1:0] MODE_REMOVED = 2'd0;
	localparam logic [1:0] MODE_SUSPENDED = 2'd1;
	localparam logic [1:0] MODE_READY = 2'd2;
	localparam logic [1:0] MODE_WAITING = 2'd3;

	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_BAD_INDEX = 2'd1;
	localparam logic [1:0] ST_ABSENT = 2'd2;

	localparam logic [7:0] LOAD_SAT = 8'd255;
	localparam logic [7:0] TOTAL_CAP = 8'd100;

	// one slot's architectural state
	typedef struct packed {
		logic        used;
		logic [1:0]  mode;
		logic [15:0] period;
		logic [15:0] countdown;
		logic [31:0] cycle_sum;
		logic [7:0]  load;
	} slot_t;

	// scan token passed from cell to cell; total holds up to 32 loads of 255
	typedef struct packed {
		logic        found;
		logic [5:0]  pick;
		logic [12:0] total;
	} token_t;

	// command broadcast to every cell during a slot op
	typedef struct packed {
		logic        op;
		logic [3:0]  kind;
		logic [1:0]  mode;
		logic [15:0] period;
		logic [31:0] cycles;
	} cmd_t;
endpackage

// File: src/pts_divider.sv
// Restoring divider for load computation, one quotient bit per cycle
module pts_divider import pts_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [31:0] dividend,
	input  logic [31:0] divisor,
	output logic        done,
	output logic [7:0]  load
);
	logic [31:0] quo_q;
	logic [31:0] rem_q;
	logic [31:0] dvs_q;
	logic [5:0]  cnt_q;
	logic        busy_q;
	logic [32:0] trial;

	assign trial = {rem_q, quo_q[31]} - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q <= 6'd32;
		end else if (busy_q) begin
			cnt_q <= cnt_q - 6'd1;
			if (cnt_q == 6'd1) busy_q <= 1'b0;
		end
	end

	// remainder stays below the divisor, so a restored shift never loses its top bit
	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= (divisor == '0) ? 32'd1 : divisor;
		end else if (busy_q) begin
			if (!trial[32]) begin
				rem_q <= trial[31:0];
				quo_q <= {quo_q[30:0], 1'b1};
			end else begin
				rem_q <= {rem_q[30:0], quo_q[31]};
				quo_q <= {quo_q[30:0], 1'b0};
			end
		end
	end

	assign done = busy_q && (cnt_q == 6'd1) ? 1'b0 : (!busy_q);
	assign load = (quo_q > 32'd255) ? LOAD_SAT : quo_q[7:0];
endmodule

// File: src/pts_cell.sv
// One task slot cell: holds the slot state and passes the scan token on
module pts_cell import pts_pkg::*; #(
	parameter int IDX = 0
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        sel,
	input  cmd_t        cmd,
	input  logic        scan_en,
	input  logic [5:0]  running,
	input  token_t      tok_in,
	output token_t      tok_out,
	input  logic        load_we,
	input  logic [7:0]  load_in,
	output slot_t       slot
);
	slot_t  s_q;
	logic   expire;
	logic [15:0] dec;

	assign slot = s_q;
	assign dec = s_q.countdown - 16'd1;
	assign expire = s_q.used && s_q.mode == MODE_SUSPENDED && dec == '0;

	// token: first ready-not-running or newly expired slot wins
	always_comb begin
		tok_out = tok_in;
		tok_out.total = tok_in.total + (s_q.used ? {5'b0, s_q.load} : 13'd0);
		if (!tok_in.found && s_q.used) begin
			if ((s_q.mode == MODE_READY && running != 6'(IDX)) || expire) begin
				tok_out.found = 1'b1;
				tok_out.pick = 6'(IDX);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_q <= '0;
		end else if (scan_en) begin
			if (s_q.used && s_q.mode == MODE_SUSPENDED) begin
				s_q.countdown <= expire ? s_q.period : dec;
				if (expire) s_q.mode <= MODE_READY;
			end
		end else if (load_we) begin
			s_q.load <= load_in;
			s_q.cycle_sum <= '0;
		end else if (sel && cmd.op) begin
			unique case (cmd.kind)
				KIND_CREATE: begin
					s_q.used <= 1'b1;
					s_q.mode <= MODE_SUSPENDED;
					s_q.period <= cmd.period;
					s_q.countdown <= cmd.period;
				end
				KIND_DELETE: begin
					s_q.used <= 1'b0;
					s_q.mode <= MODE_REMOVED;
					s_q.period <= '0;
					s_q.countdown <= '0;
				end
				KIND_SUSPEND, KIND_RESUME, KIND_WAIT: s_q.mode <= cmd.mode;
				KIND_FINISH: begin
					s_q.cycle_sum <= s_q.cycle_sum + cmd.cycles;
					s_q.mode <= MODE_SUSPENDED;
				end
				default: ;
			endcase
		end
	end
endmodule

// File: src/periodic_task_scheduler_unit.sv
// Periodic task scheduler: a row of slot cells, a control sequencer and a load divider.
// A slot item or tick is taken in IDLE and runs in EXEC, which registers its result.
// A tick that closes a load window adds a walk over the slots in WIN, with a DIV state
// per present slot for the shared bit-serial divider. The result sits in an output
// register; the next beat is taken in the cycle it is delivered, or any later cycle.
`include "periodic_task_scheduler_unit_macros.svh"
module periodic_task_scheduler_unit import pts_pkg::*; #(
	parameter int TASK_SLOTS = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// [3:0] kind, [11:4] task_req, [27:12] period, [59:28] cycles, zero fill
	input  logic [63:0] s_tdata,
	output logic        m_tvalid,
	input  logic        m_tready,
	// [1:0] status, [2] dispatch_valid, [6:3] dispatch_task, [14:7] load_value
	output logic [15:0] m_tdata,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	localparam int SW = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;
	localparam logic [2:0] S_IDLE = 3'd0, S_EXEC = 3'd1, S_WIN = 3'd2,
		S_DIV = 3'd3, S_OUT = 3'd4;

	logic [31:0] cpp_q;
	logic [15:0] lwt_q;
	logic [15:0] win_q;
	logic [5:0]  run_q;
	logic [2:0]  st_q;
	logic [59:0] item_q;
	logic [5:0]  wi_q;
	logic        outv_q;
	logic [14:0] out_q;

	logic [3:0]  kind;
	logic [7:0]  idx;
	logic        vidx;
	slot_t       slots [TASK_SLOTS];
	token_t      toks [TASK_SLOTS+1];
	cmd_t        cmd;
	logic        scan_en;
	logic        div_start, div_done;
	logic [7:0]  div_load;
	logic [15:0] win_inc;
	slot_t       cur;
	logic [14:0] res;
	logic        win_end;

	assign pready = 1'b1;
	assign prdata = (paddr == 3'd0) ? cpp_q : (paddr == 3'd4) ? {16'd0, lwt_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cpp_q <= 32'd1800000;
			lwt_q <= 16'd1000;
		end else if (psel && penable && pwrite) begin
			if (paddr == 3'd0) cpp_q <= pwdata;
			else if (paddr == 3'd4) lwt_q <= pwdata[15:0];
		end
	end

	assign kind = item_q[3:0];
	assign idx = item_q[11:4];
	assign vidx = {24'd0, idx} < TASK_SLOTS;
	assign cur = slots[vidx ? idx[SW-1:0] : '0];
	assign win_inc = win_q + 16'd1;

	always_comb begin
		cmd.op = st_q == S_EXEC && vidx;
		cmd.kind = kind;
		cmd.mode = kind == KIND_SUSPEND ? MODE_SUSPENDED :
			kind == KIND_RESUME ? MODE_READY : MODE_WAITING;
		cmd.period = item_q[27:12];
		cmd.cycles = item_q[59:28];
		if ((kind == KIND_DELETE || kind == KIND_FINISH) && !cur.used) cmd.op = 1'b0;
	end
	assign scan_en = st_q == S_EXEC && kind == KIND_TICK;
	assign toks[0] = '0;

	for (genvar g = 0; g < TASK_SLOTS; g++) begin : g_cell
		pts_cell #(.IDX(g)) u_cell (
			.clk, .arst_n,
			.sel(idx == 8'(g)), .cmd, .scan_en, .running(run_q),
			.tok_in(toks[g]), .tok_out(toks[g+1]),
			.load_we(st_q == S_DIV && div_done && !div_start && wi_q == 6'(g)
				&& slots[g].used),
			.load_in(div_load), .slot(slots[g])
		);
	end

	assign div_start = st_q == S_WIN && wi_q < 6'(TASK_SLOTS) &&
		slots[wi_q[SW-1:0]].used;
	pts_divider u_div (
		.clk, .arst_n, .start(div_start),
		.dividend(slots[wi_q < 6'(TASK_SLOTS) ? wi_q[SW-1:0] : '0].cycle_sum),
		.divisor(cpp_q), .done(div_done), .load(div_load)
	);

	assign s_tready = st_q == S_IDLE && (!outv_q || m_tready);
	assign m_tvalid = outv_q;
	assign m_tdata = {1'b0, out_q};

	// result of the item in execution
	always_comb begin
		res = '0;
		win_end = 1'b0;
		priority if (kind == KIND_TICK) begin
			if (toks[TASK_SLOTS].found) begin
				res[2] = 1'b1;
				res[6:3] = toks[TASK_SLOTS].pick[3:0];
			end
			win_end = win_inc >= lwt_q;
		end else if (kind == KIND_TOTAL) begin
			res[14:7] = toks[TASK_SLOTS].total > 13'd100 ? TOTAL_CAP :
				toks[TASK_SLOTS].total[7:0];
		end else if (kind > KIND_TOTAL) begin
		end else if (!vidx) res[1:0] = ST_BAD_INDEX;
		else if ((kind == KIND_DELETE || kind == KIND_FINISH ||
			kind == KIND_TLOAD) && !cur.used) res[1:0] = ST_ABSENT;
		else if (kind == KIND_FINISH) begin
			res[2] = 1'b1;
			res[6:3] = 4'(TASK_SLOTS);
		end else if (kind == KIND_TLOAD) res[14:7] = cur.load;
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= S_IDLE;
			run_q <= 6'(TASK_SLOTS);
			win_q <= '0;
			outv_q <= 1'b0;
			wi_q <= '0;
		end else begin
			unique case (st_q)
				S_IDLE: begin
					if (outv_q && m_tready) outv_q <= 1'b0;
					if (s_tvalid && s_tready) st_q <= S_EXEC;
				end
				S_EXEC: begin
					outv_q <= !win_end;
					wi_q <= '0;
					st_q <= win_end ? S_WIN : S_IDLE;
					if (kind == KIND_TICK) begin
						win_q <= win_end ? '0 : win_inc;
						if (toks[TASK_SLOTS].found) run_q <= toks[TASK_SLOTS].pick;
					end else if (res[2]) run_q <= 6'(TASK_SLOTS);
				end
				S_WIN: begin
					if (wi_q == 6'(TASK_SLOTS)) begin
						outv_q <= 1'b1;
						st_q <= S_IDLE;
					end else if (div_start) st_q <= S_DIV;
					else wi_q <= wi_q + 6'd1;
				end
				S_DIV: if (div_done) begin
					wi_q <= wi_q + 6'd1;
					st_q <= S_WIN;
				end
				default: st_q <= S_IDLE;
			endcase
		end
	end

	// item and result holding registers
	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) item_q <= s_tdata[59:0];
		if (st_q == S_EXEC) out_q <= res;
	end

	`PTS_ASSERT(a_noacc_busy, clk, arst_n, (st_q != S_IDLE) |-> !s_tready)
	`PTS_ASSERT(a_run_range, clk, arst_n, run_q <= 6'(TASK_SLOTS))
	`PTS_ASSERT(a_out_after_exec, clk, arst_n,
		(st_q == S_EXEC && kind != KIND_TICK) |=> outv_q)
endmodule

// File: tb/tb.sv
// Self-checking testbench for the periodic task scheduler unit
module tb;
	import pts_pkg::*;

	localparam int SLOTS = 8;
	localparam logic [3:0] IDLE_TASK = 4'd8;
	localparam logic [2:0] ADDR_CPP = 3'd0;
	localparam logic [2:0] ADDR_WINDOW = 3'd4;
	// window ends run the divider once per present slot
	localparam int SETTLE_CYCLES = 400;

	typedef struct {
		logic [3:0]  kind;
		logic [7:0]  task_req;
		logic [15:0] period;
		logic [31:0] cycles;
	} sched_req_t;

	typedef struct {
		logic [1:0] status;
		logic       dispatch_valid;
		logic [3:0] dispatch_task;
		logic [7:0] load_value;
	} sched_rsp_t;

	// scheduler predictor plus queue of pending expected responses
	class sched_scoreboard;
		logic        used [SLOTS];
		logic [1:0]  mode [SLOTS];
		logic [15:0] period [SLOTS];
		logic [15:0] countdown [SLOTS];
		logic [31:0] cycle_sum [SLOTS];
		logic [7:0]  load [SLOTS];
		logic [3:0]  running;
		logic [15:0] window_count;
		logic [31:0] cycles_per_pct;
		logic [15:0] window_ticks;
		sched_rsp_t  pending_rsp [$];
		int          errors;
		int          checked;

		function new();
			for (int i = 0; i < SLOTS; i++) begin
				used[i] = 1'b0;
				mode[i] = MODE_REMOVED;
				period[i] = '0;
				countdown[i] = '0;
				cycle_sum[i] = '0;
				load[i] = '0;
			end
			running = IDLE_TASK;
			window_count = '0;
			cycles_per_pct = 32'd1800000;
			window_ticks = 16'd1000;
			errors = 0;
			checked = 0;
		endfunction

		// per-slot load update at the end of a measurement window
		function void close_window();
			logic [31:0] divisor;
			logic [31:0] quot;
			divisor = (cycles_per_pct == 0) ? 32'd1 : cycles_per_pct;
			for (int i = 0; i < SLOTS; i++) begin
				if (used[i]) begin
					quot = cycle_sum[i] / divisor;
					load[i] = (quot > 255) ? LOAD_SAT : quot[7:0];
					cycle_sum[i] = '0;
				end
			end
		endfunction

		function void note_request(sched_req_t r);
			sched_rsp_t rsp;
			bit         in_range;
			int         s;
			bit         found;
			int         pick;
			int         total;
			rsp = '{ST_OK, 1'b0, 4'd0, 8'd0};
			in_range = r.task_req < SLOTS;
			s = in_range ? r.task_req : 0;
			case (r.kind)
				KIND_TICK: begin
					found = 0;
					pick = 0;
					for (int i = 0; i < SLOTS; i++) begin
						if (!used[i] || mode[i] == MODE_REMOVED || mode[i] == MODE_WAITING)
							continue;
						if (mode[i] == MODE_READY) begin
							if (i != running && !found) begin
								found = 1;
								pick = i;
							end
							continue;
						end
						countdown[i] = countdown[i] - 16'd1;
						if (countdown[i] == 0) begin
							countdown[i] = period[i];
							mode[i] = MODE_READY;
							if (!found) begin
								found = 1;
								pick = i;
							end
						end
					end
					if (found) begin
						rsp.dispatch_valid = 1'b1;
						rsp.dispatch_task = pick[3:0];
						running = pick[3:0];
					end
					window_count = window_count + 16'd1;
					if (window_count >= window_ticks) begin
						window_count = '0;
						close_window();
					end
				end
				KIND_CREATE: begin
					if (!in_range) rsp.status = ST_BAD_INDEX;
					else begin
						period[s] = r.period;
						countdown[s] = r.period;
						used[s] = 1'b1;
						mode[s] = MODE_SUSPENDED;
					end
				end
				KIND_DELETE: begin
					if (!in_range) rsp.status = ST_BAD_INDEX;
					else if (!used[s]) rsp.status = ST_ABSENT;
					else begin
						used[s] = 1'b0;
						mode[s] = MODE_REMOVED;
						period[s] = '0;
						countdown[s] = '0;
					end
				end
				KIND_SUSPEND, KIND_RESUME, KIND_WAIT: begin
					if (!in_range) rsp.status = ST_BAD_INDEX;
					else mode[s] = (r.kind == KIND_SUSPEND) ? MODE_SUSPENDED :
						(r.kind == KIND_RESUME) ? MODE_READY : MODE_WAITING;
				end
				KIND_FINISH: begin
					if (!in_range) rsp.status = ST_BAD_INDEX;
					else if (!used[s]) rsp.status = ST_ABSENT;
					else begin
						cycle_sum[s] = cycle_sum[s] + r.cycles;
						mode[s] = MODE_SUSPENDED;
						running = IDLE_TASK;
						rsp.dispatch_valid = 1'b1;
						rsp.dispatch_task = IDLE_TASK;
					end
				end
				KIND_TLOAD: begin
					if (!in_range) rsp.status = ST_BAD_INDEX;
					else if (!used[s]) rsp.status = ST_ABSENT;
					else rsp.load_value = load[s];
				end
				KIND_TOTAL: begin
					total = 0;
					for (int i = 0; i < SLOTS; i++)
						if (used[i]) total += load[i];
					rsp.load_value = (total > 100) ? TOTAL_CAP : total[7:0];
				end
				default: ;
			endcase
			pending_rsp.push_back(rsp);
		endfunction

		function void check_result(sched_rsp_t act);
			sched_rsp_t exp_rsp;
			if (pending_rsp.size() == 0) begin
				$display("%0t: unexpected response status=%0d dv=%0d task=%0d load=%0d",
					$time, act.status, act.dispatch_valid, act.dispatch_task, act.load_value);
				errors++;
				return;
			end
			exp_rsp = pending_rsp.pop_front();
			checked++;
			if (act.status !== exp_rsp.status) begin
				$display("%0t: status expected %0d actual %0d", $time, exp_rsp.status, act.status);
				errors++;
			end
			if (act.dispatch_valid !== exp_rsp.dispatch_valid) begin
				$display("%0t: dispatch_valid expected %0d actual %0d", $time,
					exp_rsp.dispatch_valid, act.dispatch_valid);
				errors++;
			end
			if (act.dispatch_task !== exp_rsp.dispatch_task) begin
				$display("%0t: dispatch_task expected %0d actual %0d", $time,
					exp_rsp.dispatch_task, act.dispatch_task);
				errors++;
			end
			if (act.load_value !== exp_rsp.load_value) begin
				$display("%0t: load_value expected %0d actual %0d", $time,
					exp_rsp.load_value, act.load_value);
				errors++;
			end
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [63:0] s_tdata;
	logic        m_tvalid;
	logic        m_tready;
	logic [15:0] m_tdata;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	sched_scoreboard sb;
	bit quiet;
	int stall_left;
	int kind_count [16];
	int cfg_writes;

	periodic_task_scheduler_unit #(.TASK_SLOTS(SLOTS)) i_dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	always #2 clk = ~clk;

	// receiver back-pressure in random bursts
	always @(posedge clk) begin
		if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			m_tready <= 1'b0;
		end else if (!quiet && $urandom_range(0, 11) == 0) begin
			stall_left <= $urandom_range(1, 17) - 1;
			m_tready <= 1'b0;
		end else begin
			m_tready <= 1'b1;
		end
	end

	// response monitor
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			sb.check_result('{m_tdata[1:0], m_tdata[2], m_tdata[6:3], m_tdata[14:7]});
	end

	task automatic push_request(sched_req_t r);
		if (!quiet && $urandom_range(0, 9) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 17)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {4'd0, r.cycles, r.period, r.task_req, r.kind};
		do @(posedge clk); while (!s_tready);
		sb.note_request(r);
		kind_count[r.kind]++;
	endtask

	task automatic send(logic [3:0] kind, logic [7:0] idx, logic [15:0] per, logic [31:0] cyc);
		push_request('{kind, idx, per, cyc});
	endtask

	// drain the block: stop sending, wait for every pending response, then let it settle
	task automatic drain();
		@(posedge clk);
		s_tvalid <= 1'b0;
		while (sb.pending_rsp.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(logic [2:0] addr, logic [31:0] data);
		psel <= 1'b1;
		pwrite <= 1'b1;
		penable <= 1'b0;
		paddr <= addr;
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		if (addr == ADDR_CPP) sb.cycles_per_pct = data;
		else sb.window_ticks = data[15:0];
		cfg_writes++;
	endtask

	task automatic configure(logic [31:0] cpp, logic [15:0] win);
		drain();
		write_reg(ADDR_CPP, cpp);
		write_reg(ADDR_WINDOW, {16'd0, win});
	endtask

	// mostly well-formed traffic: ticks, creates, finishes (mostly of the running task), mode changes, deletes, queries
	task automatic random_item();
		sched_req_t r;
		int roll;
		roll = $urandom_range(0, 99);
		r.task_req = ($urandom_range(0, 19) == 0) ? 8'($urandom_range(8, 255)) :
			8'($urandom_range(0, 7));
		r.cycles = $urandom_range(0, 1) ? $urandom : $urandom_range(0, 5000);
		case ($urandom_range(0, 9))
			0: r.period = 16'd0;
			1, 2: r.period = 16'($urandom);
			default: r.period = 16'($urandom_range(1, 12));
		endcase
		if (roll < 40) r.kind = KIND_TICK;
		else if (roll < 50) r.kind = KIND_CREATE;
		else if (roll < 65) begin
			r.kind = KIND_FINISH;
			if (sb.running != IDLE_TASK && $urandom_range(0, 3) != 0)
				r.task_req = {4'd0, sb.running};
		end
		else if (roll < 70) r.kind = KIND_SUSPEND;
		else if (roll < 75) r.kind = KIND_RESUME;
		else if (roll < 78) r.kind = KIND_WAIT;
		else if (roll < 82) r.kind = KIND_DELETE;
		else if (roll < 90) r.kind = KIND_TLOAD;
		else if (roll < 96) r.kind = KIND_TOTAL;
		else r.kind = 4'($urandom_range(9, 15));
		push_request(r);
	endtask

	initial begin
		sb = new();
		clk = 1'b0;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		m_tready = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		quiet = 1'b0;
		stall_left = 0;
		cfg_writes = 0;
		foreach (kind_count[k]) kind_count[k] = 0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		repeat (SETTLE_CYCLES) @(posedge clk);

		// directed: index limits, absent slots, period limits, unknown kinds
		send(KIND_CREATE, 8'd255, 16'd5, 32'd0);
		send(KIND_CREATE, 8'd0, 16'd1, 32'd0);
		send(KIND_CREATE, 8'd7, 16'hFFFF, 32'd0);
		send(KIND_TICK, 8'd0, 16'd0, 32'd0);
		send(KIND_TICK, 8'd0, 16'd0, 32'd0);
		send(KIND_RESUME, 8'd7, 16'd0, 32'd0);
		send(KIND_TICK, 8'd0, 16'd0, 32'd0);
		send(KIND_FINISH, 8'd0, 16'd0, 32'hFFFF_FFFF);
		send(KIND_FINISH, 8'd0, 16'd0, 32'hFFFF_FFFF);
		send(KIND_FINISH, 8'd7, 16'd0, 32'd1);
		send(KIND_FINISH, 8'd3, 16'd0, 32'd1);
		send(KIND_DELETE, 8'd3, 16'd0, 32'd0);
		send(KIND_DELETE, 8'd8, 16'd0, 32'd0);
		send(KIND_SUSPEND, 8'd3, 16'd0, 32'd0);
		send(KIND_WAIT, 8'd4, 16'd0, 32'd0);
		send(KIND_TICK, 8'd0, 16'd0, 32'd0);
		send(KIND_TLOAD, 8'd3, 16'd0, 32'd0);
		send(KIND_TLOAD, 8'd0, 16'd0, 32'd0);
		send(KIND_TLOAD, 8'd200, 16'd0, 32'd0);
		send(KIND_TOTAL, 8'd0, 16'd0, 32'd0);
		send(4'd9, 8'hFF, 16'hFFFF, 32'hFFFF_FFFF);
		send(4'd15, 8'd1, 16'd1, 32'd1);
		send(KIND_CREATE, 8'd5, 16'd0, 32'd0);
		send(KIND_DELETE, 8'd5, 16'd0, 32'd0);

		// random phases over several register settings
		for (int phase = 0; phase < 5; phase++) begin
			case (phase)
				1: configure(32'd1, 16'd1);
				2: configure(32'hFFFF_FFFF, 16'hFFFF);
				3: configure($urandom_range(1000, 50000000), 16'($urandom_range(2, 20)));
				4: begin
					configure($urandom_range(1, 1 << 20), 16'($urandom_range(3, 10)));
					quiet = 1'b1;
				end
				default: ;
			endcase
			repeat (340) random_item();
		end

		// zero period: the countdown wraps, so the slot stays quiet over a run of ticks
		configure($urandom_range(1, 1 << 24), 16'hFFFF);
		for (int i = 1; i < SLOTS; i++) send(KIND_DELETE, 8'(i), 16'd0, 32'd0);
		send(KIND_CREATE, 8'd0, 16'd0, 32'd0);
		repeat (16) send(KIND_TICK, 8'd0, 16'd0, 32'd0);
		send(KIND_TOTAL, 8'd0, 16'd0, 32'd0);

		drain();
		$display("Covered %0d ticks, %0d creates, %0d finishes, %0d load queries, %0d register writes",
			kind_count[KIND_TICK], kind_count[KIND_CREATE], kind_count[KIND_FINISH],
			kind_count[KIND_TLOAD] + kind_count[KIND_TOTAL], cfg_writes);
		$display("%0d responses checked, %0d mismatches", sb.checked, sb.errors);
		if (sb.errors == 0 && sb.pending_rsp.size() == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

	// watchdog
	initial begin
		#20000000;
		$display("Timeout waiting for the scheduler");
		$display("Verification failed");
		$finish;
	end
endmodule
